// ----- rtl/core/etf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape-time fractal package
// Shared types and constants for the escape-time fractal pixel block.
// ----------------------------------------------------------------------------
package etf_pkg;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE     = 3'd0,
        REG_MAX_ITER = 3'd1,
        REG_C_REAL   = 3'd2,
        REG_C_IMAG   = 3'd3,
        REG_EXPONENT = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_MUL,
        ST_ADD,
        ST_COLOR,
        ST_DIV,
        ST_OUT
    } etf_state_t;

    typedef enum logic [2:0] {
        MOP_SQ_R,
        MOP_SQ_I,
        MOP_RR,
        MOP_II,
        MOP_RI,
        MOP_IR
    } mul_op_t;

    typedef struct packed {
        logic    load;
        logic    mul_go;
        mul_op_t mul_op;
        logic    mul_hi;
        logic    mag_check;
        logic    cx_start;
        logic    cx_step;
        logic    add_c;
        logic    div_start;
        logic    div_step;
    } etf_cmd_t;

    typedef struct packed {
        logic escape;
        logic div_done;
    } etf_status_t;

    localparam int GRAY_MAX  = 255;
    localparam int BLUE_ADD  = 88;

endpackage

// ----- rtl/core/etf_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape-time fractal datapath
// Holds z, the constant c, one fixed-point multiplier and a serial divider.
// ----------------------------------------------------------------------------
module etf_datapath import etf_pkg::*; #(
    parameter int ITER_W    = 13,
    parameter int FRAC_BITS = 28
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  etf_cmd_t          cmd,
    output etf_status_t       status,
    input  logic              mode,
    input  logic [31:0]       c_real_cfg,
    input  logic [31:0]       c_imag_cfg,
    input  logic [31:0]       point_real,
    input  logic [31:0]       point_imag,
    input  logic [ITER_W-1:0] lim,
    input  logic [ITER_W-1:0] it,
    output logic [7:0]        gray
);

    localparam int ZW = FRAC_BITS + 12;
    localparam int PW = 2 * ZW;
    localparam int LW = ZW / 2;
    localparam int QW = ITER_W + 8;
    localparam logic signed [ZW-1:0] ZMAX = {1'b0, {(ZW-1){1'b1}}};
    localparam logic signed [ZW-1:0] ZMIN = {1'b1, {(ZW-1){1'b0}}};

    function automatic logic signed [ZW-1:0] from_q(input logic [31:0] raw);
        logic signed [ZW+31:0] w;
        w = {{ZW{raw[31]}}, raw};
        if (FRAC_BITS >= 28) begin
            w = w <<< (FRAC_BITS - 28);
        end else begin
            w = w >>> (28 - FRAC_BITS);
        end
        return w[ZW-1:0];
    endfunction

    function automatic logic signed [ZW-1:0] clampw(input logic signed [ZW:0] v);
        if (v > $signed({ZMAX[ZW-1], ZMAX})) begin
            return ZMAX;
        end else if (v < $signed({ZMIN[ZW-1], ZMIN})) begin
            return ZMIN;
        end
        return v[ZW-1:0];
    endfunction

    logic signed [ZW-1:0] zr_reg, zi_reg, wr_reg, wi_reg, cr_reg, ci_reg;
    logic signed [ZW-1:0] a_sel, b_sel;
    logic signed [LW:0]   b_part;
    logic signed [ZW+LW:0] part;
    logic signed [PW-1:0] lo_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [ZW-1:0] prod_s;
    logic signed [ZW-1:0] p0_reg, p1_reg, p2_reg;
    logic signed [ZW:0]   mag_sum;
    logic [QW-1:0]        rem_reg, quo_reg, dvd_reg;
    logic [$clog2(QW+1)-1:0] dcnt_reg;
    logic [QW:0]          rem_sh;
    logic                 escape_reg;

    always_comb begin
        a_sel = zr_reg;
        b_sel = zr_reg;
        case (cmd.mul_op)
            MOP_SQ_R: begin a_sel = zr_reg; b_sel = zr_reg; end
            MOP_SQ_I: begin a_sel = zi_reg; b_sel = zi_reg; end
            MOP_RR:   begin a_sel = wr_reg; b_sel = zr_reg; end
            MOP_II:   begin a_sel = wi_reg; b_sel = zi_reg; end
            MOP_RI:   begin a_sel = wr_reg; b_sel = zi_reg; end
            MOP_IR:   begin a_sel = wi_reg; b_sel = zr_reg; end
            default:  begin a_sel = zr_reg; b_sel = zr_reg; end
        endcase
    end

    // The product is built from the low and the high half of b.
    always_comb begin
        if (cmd.mul_hi) begin
            b_part = (LW+1)'(b_sel >>> LW);
        end else begin
            b_part = $signed({1'b0, b_sel[LW-1:0]});
        end
    end

    assign part = (ZW+LW+1)'(a_sel) * (ZW+LW+1)'(b_part);

    // Floor shift of the exact product, then saturation to the z width.
    always_comb begin
        logic signed [PW-1:0] sh;
        logic [PW-1:0]        hi_bits;
        sh = prod_reg >>> FRAC_BITS;
        hi_bits = PW'(sh >>> (ZW - 1));
        if (hi_bits == '0 || hi_bits == '1) begin
            prod_s = sh[ZW-1:0];
        end else if (sh[PW-1]) begin
            prod_s = ZMIN;
        end else begin
            prod_s = ZMAX;
        end
    end

    assign mag_sum = {p0_reg[ZW-1], p0_reg} + {prod_s[ZW-1], prod_s};
    assign rem_sh  = {rem_reg, dvd_reg[QW-1]};

    always_ff @(posedge aclk) begin
        if (cmd.mul_hi) begin
            prod_reg <= (PW'(part) <<< LW) + lo_reg;
        end else begin
            lo_reg <= PW'(part);
        end
        if (cmd.mul_go) begin
            p2_reg <= p1_reg;
            p1_reg <= p0_reg;
            p0_reg <= prod_s;
        end
        if (cmd.load) begin
            if (mode) begin
                zr_reg <= from_q(point_real);
                zi_reg <= from_q(point_imag);
                cr_reg <= from_q(c_real_cfg);
                ci_reg <= from_q(c_imag_cfg);
            end else begin
                zr_reg <= '0;
                zi_reg <= '0;
                cr_reg <= from_q(point_real);
                ci_reg <= from_q(point_imag);
            end
        end
        if (cmd.cx_start) begin
            wr_reg <= zr_reg;
            wi_reg <= zi_reg;
        end
        if (cmd.cx_step) begin
            wr_reg <= clampw({p2_reg[ZW-1], p2_reg} - {p1_reg[ZW-1], p1_reg});
            wi_reg <= clampw({p0_reg[ZW-1], p0_reg} + {prod_s[ZW-1], prod_s});
        end
        if (cmd.add_c) begin
            zr_reg <= clampw({wr_reg[ZW-1], wr_reg} + {cr_reg[ZW-1], cr_reg});
            zi_reg <= clampw({wi_reg[ZW-1], wi_reg} + {ci_reg[ZW-1], ci_reg});
        end
        if (cmd.div_start) begin
            dvd_reg  <= QW'((lim - it) * 255);
            rem_reg  <= '0;
            quo_reg  <= '0;
            dcnt_reg <= '0;
        end else if (cmd.div_step) begin
            dvd_reg  <= dvd_reg << 1;
            dcnt_reg <= dcnt_reg + 1'b1;
            if (rem_sh >= {1'b0, QW'(lim)}) begin
                rem_reg <= QW'(rem_sh - {1'b0, QW'(lim)});
                quo_reg <= {quo_reg[QW-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[QW-1:0];
                quo_reg <= {quo_reg[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            escape_reg <= 1'b0;
        end else if (cmd.mag_check) begin
            escape_reg <= mag_sum > $signed((ZW+1)'(4) <<< FRAC_BITS);
        end
    end

    assign status.escape   = escape_reg;
    assign status.div_done = (dcnt_reg == ($clog2(QW+1))'(QW));
    assign gray            = 8'(GRAY_MAX - quo_reg[7:0]);

endmodule

// ----- rtl/core/etf_control.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape-time fractal controller
// Sequences the escape test, complex power, constant add and color division.
// ----------------------------------------------------------------------------
module etf_control import etf_pkg::*; #(
    parameter int ITER_W = 13,
    parameter int EXP_W  = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic              out_taken,
    input  logic [ITER_W-1:0] lim,
    input  logic [EXP_W-1:0]  n_pow,
    input  etf_status_t       status,
    output etf_cmd_t          cmd,
    output logic              busy,
    output logic              out_valid,
    output logic              escaped,
    output logic [ITER_W-1:0] it
);

    etf_state_t        state_reg, state_next;
    logic [3:0]        ph_reg, ph_next;
    logic [EXP_W-1:0]  k_reg, k_next;
    logic [ITER_W-1:0] it_reg, it_next;
    logic              esc_reg, esc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ph_reg    <= '0;
            k_reg     <= '0;
            it_reg    <= '0;
            esc_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            k_reg     <= k_next;
            it_reg    <= it_next;
            esc_reg   <= esc_next;
        end
    end

    // Each product is issued as a low half first, then a high half.
    // Test phases: 0-1 issue zr^2, 2-3 issue zi^2, 2 latch zr^2, 4 compare, 5 decide.
    // Product phases: 0-7 issue rr, ii, ri, ir; 2, 4, 6 latch; 8 update w.
    always_comb begin
        state_next = state_reg;
        ph_next    = ph_reg;
        k_next     = k_reg;
        it_next    = it_reg;
        esc_next   = esc_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    it_next  = '0;
                    esc_next = 1'b0;
                    ph_next  = '0;
                    state_next = (lim == '0) ? ST_OUT : ST_TEST;
                end
            end
            ST_TEST: begin
                ph_next = ph_reg + 4'd1;
                if (ph_reg == 4'd5) begin
                    ph_next = '0;
                    if (status.escape) begin
                        esc_next   = 1'b1;
                        state_next = ST_COLOR;
                    end else if (n_pow == EXP_W'(1)) begin
                        state_next = ST_ADD;
                    end else begin
                        k_next     = EXP_W'(1);
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                ph_next = ph_reg + 4'd1;
                if (ph_reg == 4'd8) begin
                    ph_next = '0;
                    k_next  = k_reg + 1'b1;
                    if (k_reg + 1'b1 == n_pow) begin
                        state_next = ST_ADD;
                    end
                end
            end
            ST_ADD: begin
                it_next = it_reg + 1'b1;
                state_next = (it_reg + 1'b1 == lim) ? ST_OUT : ST_TEST;
            end
            ST_COLOR: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_taken) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.mul_op = MOP_SQ_R;
        case (state_reg)
            ST_IDLE: begin
                cmd.load = start;
            end
            ST_TEST: begin
                cmd.cx_start = 1'b1;
                if (ph_reg >= 4'd2) begin
                    cmd.mul_op = MOP_SQ_I;
                end
                cmd.mul_hi    = ph_reg[0];
                cmd.mul_go    = (ph_reg == 4'd2);
                cmd.mag_check = (ph_reg == 4'd4);
            end
            ST_MUL: begin
                case (ph_reg)
                    4'd0, 4'd1: cmd.mul_op = MOP_RR;
                    4'd2, 4'd3: cmd.mul_op = MOP_II;
                    4'd4, 4'd5: cmd.mul_op = MOP_RI;
                    4'd6, 4'd7: cmd.mul_op = MOP_IR;
                    default: cmd.mul_op = MOP_RR;
                endcase
                cmd.mul_hi  = ph_reg[0];
                cmd.mul_go  = (ph_reg == 4'd2) || (ph_reg == 4'd4) || (ph_reg == 4'd6);
                cmd.cx_step = (ph_reg == 4'd8);
            end
            ST_ADD: begin
                cmd.add_c = 1'b1;
            end
            ST_COLOR: begin
                cmd.div_start = 1'b1;
            end
            ST_DIV: begin
                cmd.div_step = !status.div_done;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    assign busy      = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign escaped   = esc_reg;
    assign it        = it_reg;

endmodule

// ----- rtl/core/escape_time_fractal_pixel.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape-time fractal pixel
// Each iteration runs the escape test, then the complex power for n > 1 and
// the constant add; an escaping pixel then runs the color division.
// One pixel is processed at a time, and each product is built from a low and
// a high half product. The next input is accepted in the cycle after the
// output transfer completes.
// Reset is synchronous, active low, and loads the register defaults.
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel import etf_pkg::*; #(
    parameter int ITER_LIMIT   = 4096,
    parameter int FRAC_BITS    = 28,
    parameter int MAX_EXPONENT = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // point_real [31:0], point_imag [63:32]
    input  logic [63:0]          s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // red [7:0], green [15:8], blue [23:16], iterations [36:24], inside_res [37]
    output logic [39:0]          m_tdata
);

    localparam int ITER_W = 13;
    localparam int EXP_W  = 4;

    logic              mode_reg;
    logic [ITER_W-1:0] max_it_reg;
    logic [31:0]       c_real_reg, c_imag_reg;
    logic [EXP_W-1:0]  exp_reg;
    logic [ITER_W-1:0] lim, it;
    logic [EXP_W-1:0]  n_pow;
    logic [7:0]        gray;
    logic [8:0]        blue_sum;
    logic              busy, out_valid, escaped, start;
    etf_cmd_t          cmd;
    etf_status_t       status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= 1'b0;
            max_it_reg <= ITER_W'(256);
            c_real_reg <= '0;
            c_imag_reg <= '0;
            exp_reg    <= EXP_W'(2);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MODE:     mode_reg   <= cfg_data[0];
                REG_MAX_ITER: max_it_reg <= cfg_data[ITER_W-1:0];
                REG_C_REAL:   c_real_reg <= cfg_data;
                REG_C_IMAG:   c_imag_reg <= cfg_data;
                REG_EXPONENT: exp_reg    <= cfg_data[EXP_W-1:0];
                default: ;
            endcase
        end
    end

    assign lim = (32'(max_it_reg) > ITER_LIMIT) ? ITER_W'(ITER_LIMIT) : max_it_reg;

    always_comb begin
        if (!mode_reg) begin
            n_pow = EXP_W'(2);
        end else if (exp_reg == '0) begin
            n_pow = EXP_W'(1);
        end else if (32'(exp_reg) > MAX_EXPONENT) begin
            n_pow = EXP_W'(MAX_EXPONENT);
        end else begin
            n_pow = exp_reg;
        end
    end

    assign s_tready = !busy;
    assign start    = s_tvalid && s_tready;

    etf_control #(.ITER_W(ITER_W), .EXP_W(EXP_W)) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .out_taken (m_tready),
        .lim       (lim),
        .n_pow     (n_pow),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy),
        .out_valid (out_valid),
        .escaped   (escaped),
        .it        (it)
    );

    etf_datapath #(.ITER_W(ITER_W), .FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .mode       (mode_reg),
        .c_real_cfg (c_real_reg),
        .c_imag_cfg (c_imag_reg),
        .point_real (s_tdata[31:0]),
        .point_imag (s_tdata[63:32]),
        .lim        (lim),
        .it         (it),
        .gray       (gray)
    );

    assign blue_sum = {1'b0, gray} + 9'(BLUE_ADD);
    assign m_tvalid = out_valid;

    always_comb begin
        m_tdata = '0;
        m_tdata[36:24] = escaped ? it : lim;
        m_tdata[37]    = !escaped;
        if (escaped) begin
            m_tdata[7:0]   = gray;
            m_tdata[15:8]  = gray;
            m_tdata[23:16] = blue_sum[8] ? 8'(GRAY_MAX) : blue_sum[7:0];
        end
    end

endmodule
